// ===== design/tms_pkg.sv =====
// Shared types and constants of the tumbler mix sequencer.
`default_nettype none

package tms_pkg;

  // Operating modes, coded as reported on the result channel
  typedef enum logic [1:0] {
    MODE_STOPPED = 2'd0,
    MODE_RUNNING = 2'd1,
    MODE_MANUAL  = 2'd2,
    MODE_MIXING  = 2'd3
  } tms_mode_t;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIX_INTERVAL = 3'd0,
    CFG_MIX_RUN_MIN  = 3'd1,
    CFG_NORMAL_END   = 3'd2,
    CFG_CORR_END     = 3'd3,
    CFG_CORR_RUNS    = 3'd4
  } tms_cfg_idx_t;

  // Clock limits
  localparam logic [5:0] SEC_PER_MIN   = 6'd60;
  localparam logic [5:0] MIN_PER_HOUR  = 6'd60;
  localparam logic [4:0] HOURS_PER_DAY = 5'd24;
  localparam logic [4:0] DAY_LIMIT     = 5'd30;
  localparam logic [7:0] MONTH_MAX     = 8'd255;

  // Configuration reset values
  localparam logic [4:0] RST_MIX_INTERVAL = 5'd1;
  localparam logic [5:0] RST_MIX_RUN_MIN  = 6'd2;
  localparam logic [5:0] RST_NORMAL_END   = 6'd6;
  localparam logic [5:0] RST_CORR_END     = 6'd7;
  localparam logic [3:0] RST_CORR_RUNS    = 4'd1;

  typedef struct packed {
    logic [4:0] mix_interval_hours;
    logic [5:0] mix_run_minutes;
    logic [5:0] normal_end_second;
    logic [5:0] correction_end_second;
    logic [3:0] correction_runs;
  } tms_cfg_t;

  typedef struct packed {
    logic       relay;
    tms_mode_t  mode;
    logic [7:0] months;
    logic [4:0] days;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic [5:0] seconds;
    logic [4:0] mix_hours;
    logic [5:0] mix_minutes;
    logic [5:0] mix_seconds;
    logic [3:0] run_count;
  } tms_state_t;

endpackage

`default_nettype wire

// ===== design/tms_if.sv =====
// Valid/ready channel interfaces for tick beats and status beats.
`default_nettype none

interface tms_in_if;
  logic valid;
  logic ready;
  logic control_switch;
  logic manual_switch;

  modport source (output valid, output control_switch, output manual_switch, input ready);
  modport sink   (input valid, input control_switch, input manual_switch, output ready);
endinterface

interface tms_out_if;
  logic       valid;
  logic       ready;
  logic       relay_on;
  logic [1:0] mode;
  logic [7:0] elapsed_months;
  logic [4:0] elapsed_days;
  logic [4:0] elapsed_hours;
  logic [5:0] elapsed_minutes;
  logic [5:0] elapsed_seconds;
  logic [4:0] mix_hours;
  logic [5:0] mix_minutes;
  logic [5:0] mix_seconds;
  logic [3:0] run_count;

  modport source (
    output valid, output relay_on, output mode, output elapsed_months,
    output elapsed_days, output elapsed_hours, output elapsed_minutes,
    output elapsed_seconds, output mix_hours, output mix_minutes,
    output mix_seconds, output run_count, input ready
  );
  modport sink (
    input valid, input relay_on, input mode, input elapsed_months,
    input elapsed_days, input elapsed_hours, input elapsed_minutes,
    input elapsed_seconds, input mix_hours, input mix_minutes,
    input mix_seconds, input run_count, output ready
  );
endinterface

`default_nettype wire

// ===== design/tms_step.sv =====
// One-second update of the sequencer state from the switch levels.
`default_nettype none

module tms_step (
  input  tms_pkg::tms_state_t cur,
  input  tms_pkg::tms_cfg_t   cfg,
  input  logic                control_switch,
  input  logic                manual_switch,
  output tms_pkg::tms_state_t nxt
);
  import tms_pkg::*;

  always_comb begin
    logic       active;
    tms_state_t s;
    active = (cur.mode == MODE_RUNNING) || (cur.mode == MODE_MIXING);
    s = cur;

    // Switch decode: equal levels stop, otherwise an idle block picks a mode
    if (control_switch == manual_switch) begin
      s.mode  = MODE_STOPPED;
      s.relay = 1'b0;
    end else if (!control_switch) begin
      if (!active) s.mode = MODE_RUNNING;
    end else begin
      if (!active) s.mode = MODE_MANUAL;
    end

    case (s.mode)
      MODE_STOPPED: begin
        s.months = '0; s.days = '0; s.hours = '0; s.minutes = '0; s.seconds = '0;
        s.mix_hours = '0; s.mix_minutes = '0; s.mix_seconds = '0;
        s.relay = 1'b0;
      end
      MODE_MANUAL: begin
        s.months = '0; s.days = '0; s.hours = '0; s.minutes = '0; s.seconds = '0;
        s.mix_hours = '0; s.mix_minutes = '0; s.mix_seconds = '0;
        s.run_count = '0;
        s.relay = 1'b1;
      end
      default: begin
        // Elapsed clock; the month roll looks at the day count before the carry
        s.seconds = cur.seconds + 6'd1;
        if (cur.days > DAY_LIMIT) begin
          if (cur.months != MONTH_MAX) s.months = cur.months + 8'd1;
          s.days = '0;
        end
        if (s.seconds >= SEC_PER_MIN) begin
          s.seconds = '0;
          s.minutes = s.minutes + 6'd1;
          if (s.minutes >= MIN_PER_HOUR) begin
            s.minutes = '0;
            s.hours = s.hours + 5'd1;
            if (s.hours >= HOURS_PER_DAY) begin
              s.hours = '0;
              s.days = s.days + 5'd1;
            end
          end
        end

        // Mix clock, cleared whole on a day roll
        s.mix_seconds = cur.mix_seconds + 6'd1;
        if (s.mix_seconds >= SEC_PER_MIN) begin
          s.mix_seconds = '0;
          s.mix_minutes = s.mix_minutes + 6'd1;
          if (s.mix_minutes >= MIN_PER_HOUR) begin
            s.mix_minutes = '0;
            s.mix_hours = s.mix_hours + 5'd1;
            if (s.mix_hours >= HOURS_PER_DAY) begin
              s.mix_hours = '0; s.mix_minutes = '0; s.mix_seconds = '0;
            end
          end
        end

        // Mix start
        if (s.mix_hours == cfg.mix_interval_hours) begin
          s.mode = MODE_MIXING;
          s.mix_hours = '0; s.mix_minutes = '0; s.mix_seconds = '0;
          s.relay = 1'b1;
        end

        // Mix end: normal run first, then correction run on the updated values
        if (s.mode == MODE_MIXING && s.mix_minutes == cfg.mix_run_minutes) begin
          if (s.run_count < cfg.correction_runs &&
              s.mix_seconds == cfg.normal_end_second) begin
            s.mode = MODE_RUNNING;
            s.relay = 1'b0;
            s.mix_hours = '0; s.mix_minutes = '0; s.mix_seconds = '0;
            s.run_count = s.run_count + 4'd1;
          end
          if (s.run_count == cfg.correction_runs &&
              s.mix_seconds == cfg.correction_end_second) begin
            s.mode = MODE_RUNNING;
            s.relay = 1'b0;
            s.mix_hours = '0; s.mix_minutes = '0; s.mix_seconds = '0;
            s.run_count = '0;
          end
        end
      end
    endcase

    nxt = s;
  end

endmodule

`default_nettype wire

// ===== design/tumbler_mix_sequencer_core.sv =====
// Top level of the tumbler mix sequencer: tick register, state update and status beat.
`default_nettype none

// Each input beat is a one-second tick carrying the two active-low switch
// levels; each tick yields exactly one status beat holding the mode, the relay
// drive, the elapsed clock, the mix clock and the run count as they stand after
// that tick. A tick is captured in an input register, and once the status slot
// is empty or being drained the update logic moves the state registers, which
// double as the status beat's payload. One tick is taken every cycle while the
// status side keeps up. When the status beat is not taken, the input register
// still takes one more tick before ready drops. Write the configuration only
// while no tick is in flight; writes land at once and need no handshake.

module tumbler_mix_sequencer_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [tms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tms_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  tms_in_if.sink                             in_ch,
  tms_out_if.source                          out_ch
);
  import tms_pkg::*;

  tms_cfg_t   cfg_r;
  tms_state_t state_r;
  tms_state_t state_nxt;
  logic       in_valid_r;
  logic       ctl_r;
  logic       man_r;
  logic       out_valid_r;
  logic       fire;
  logic       in_take;

  // Advance a held tick when the status slot is empty or being drained
  assign fire    = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || fire;
  assign in_take = in_ch.valid && in_ch.ready;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mix_interval_hours    <= RST_MIX_INTERVAL;
      cfg_r.mix_run_minutes       <= RST_MIX_RUN_MIN;
      cfg_r.normal_end_second     <= RST_NORMAL_END;
      cfg_r.correction_end_second <= RST_CORR_END;
      cfg_r.correction_runs       <= RST_CORR_RUNS;
    end else if (cfg_we) begin
      case (tms_cfg_idx_t'(cfg_index))
        CFG_MIX_INTERVAL: cfg_r.mix_interval_hours    <= cfg_wdata[4:0];
        CFG_MIX_RUN_MIN:  cfg_r.mix_run_minutes       <= cfg_wdata[5:0];
        CFG_NORMAL_END:   cfg_r.normal_end_second     <= cfg_wdata[5:0];
        CFG_CORR_END:     cfg_r.correction_end_second <= cfg_wdata[5:0];
        CFG_CORR_RUNS:    cfg_r.correction_runs       <= cfg_wdata[3:0];
        default: begin
          // drop writes to unused indexes
        end
      endcase
    end
  end

  // Input register: hold the tick until the update stage takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_take) begin
      in_valid_r <= 1'b1;
    end else if (fire) begin
      in_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      ctl_r <= in_ch.control_switch;
      man_r <= in_ch.manual_switch;
    end
  end

  tms_step u_step (
    .cur            (state_r),
    .cfg            (cfg_r),
    .control_switch (ctl_r),
    .manual_switch  (man_r),
    .nxt            (state_nxt)
  );

  // State registers carry the status beat; they only move when a beat is loaded
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.relay_on        = state_r.relay;
  assign out_ch.mode            = state_r.mode;
  assign out_ch.elapsed_months  = state_r.months;
  assign out_ch.elapsed_days    = state_r.days;
  assign out_ch.elapsed_hours   = state_r.hours;
  assign out_ch.elapsed_minutes = state_r.minutes;
  assign out_ch.elapsed_seconds = state_r.seconds;
  assign out_ch.mix_hours       = state_r.mix_hours;
  assign out_ch.mix_minutes     = state_r.mix_minutes;
  assign out_ch.mix_seconds     = state_r.mix_seconds;
  assign out_ch.run_count       = state_r.run_count;

endmodule

`default_nettype wire
